// File: hw/rtl/baseline_subtract_parity_demod_assert.svh
// Assertion macros for the baseline subtract block.
// They expect clk_i and rst_ni in the scope where they are used.
`ifndef BASELINE_SUBTRACT_PARITY_DEMOD_ASSERT_SVH
`define BASELINE_SUBTRACT_PARITY_DEMOD_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BSPD_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bspd check failed");
`define BSPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bspd check failed");
`else
`define BSPD_ASSERT_IMPLIES(lbl, ante, cons)
`define BSPD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/bspd_pkg.sv
package bspd_pkg;

  localparam int unsigned SAMPLE_BITS = 24;

  // Window length must stay a power of two: the mean is a shift.
  localparam int unsigned WINDOW_LEN  = 1024;
  localparam int unsigned LOG2_WINDOW = $clog2(WINDOW_LEN);
  localparam int unsigned PTR_W       = LOG2_WINDOW;
  localparam int unsigned FILL_W      = $clog2(WINDOW_LEN + 1);

  // Centre sample lags the newest sample by this many positions.
  localparam int unsigned CENTRE_LAG     = WINDOW_LEN - 1 - WINDOW_LEN / 2;
  localparam logic        CENTRE_LAG_ODD = 1'(CENTRE_LAG % 2);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic first;     // restart the running sum
    logic drop_old;  // window was full: subtract the leaving sample
    logic valid;     // full window behind this result
    logic negate;    // centre sample has odd absolute number
    logic last;
  } item_ctrl_t;

endpackage

// File: hw/rtl/bspd_front.sv
module bspd_front #(
  parameter int unsigned SAMPLE_BITS = bspd_pkg::SAMPLE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic                                first_of_record_i,
  input  logic                                last_of_record_i,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,
  input  logic [bspd_pkg::QCNT_W-1:0]         q_count_i,
  output logic                                push_o,
  output bspd_pkg::item_ctrl_t                push_ctrl_o,
  output logic [3*SAMPLE_BITS-1:0]            push_data_o
);

  localparam int unsigned PTR_W  = bspd_pkg::PTR_W;
  localparam int unsigned FILL_W = bspd_pkg::FILL_W;
  localparam int unsigned QCNT_W = bspd_pkg::QCNT_W;

  logic signed [SAMPLE_BITS-1:0] win_mem [bspd_pkg::WINDOW_LEN];

  logic              start_par_q;
  logic [FILL_W-1:0] fill_q, fill_d, fill_eff;
  logic [PTR_W-1:0]  wp_q, wp_d, wp_eff, slot;
  logic              par_q, par_eff;
  logic              full_before;
  logic              accept;
  logic [QCNT_W:0]   occupancy;

  logic                          b_v_q;
  bspd_pkg::item_ctrl_t          b_ctrl_q, ctrl_d;
  logic signed [SAMPLE_BITS-1:0] b_x_q, b_old_q, b_ctr_q;

  // Count the item in stage B too so a push never finds the queue full.
  assign occupancy  = {1'b0, q_count_i} + (QCNT_W + 1)'(b_v_q);
  assign in_stall_o = occupancy >= (QCNT_W + 1)'(bspd_pkg::QUEUE_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    fill_eff    = first_of_record_i ? '0 : fill_q;
    wp_eff      = first_of_record_i ? '0 : wp_q;
    par_eff     = first_of_record_i ? start_par_q : par_q;
    full_before = (fill_eff == FILL_W'(bspd_pkg::WINDOW_LEN));
    fill_d      = full_before ? fill_eff : fill_eff + 1'b1;
    wp_d        = wp_eff + 1'b1;
    slot        = wp_eff - PTR_W'(bspd_pkg::CENTRE_LAG);
    ctrl_d.first    = first_of_record_i;
    ctrl_d.drop_old = full_before;
    ctrl_d.valid    = full_before || (fill_eff == FILL_W'(bspd_pkg::WINDOW_LEN - 1));
    ctrl_d.negate   = par_eff ^ bspd_pkg::CENTRE_LAG_ODD;
    ctrl_d.last     = last_of_record_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_par_q <= 1'b0;
      fill_q      <= '0;
      wp_q        <= '0;
      par_q       <= 1'b0;
      b_v_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        start_par_q <= cfg_wdata_i;
      end
      if (accept) begin
        fill_q <= fill_d;
        wp_q   <= wp_d;
        par_q  <= !par_eff;
      end
      b_v_q <= accept;
    end
  end

  // Read the leaving sample before it is overwritten, and the centre sample.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_mem[wp_eff] <= sample_i;
      b_old_q         <= win_mem[wp_eff];
      b_ctr_q         <= win_mem[slot];
      b_x_q           <= sample_i;
      b_ctrl_q        <= ctrl_d;
    end
  end

  assign push_o      = b_v_q;
  assign push_ctrl_o = b_ctrl_q;
  assign push_data_o = {b_x_q, b_old_q, b_ctr_q};

endmodule

// File: hw/rtl/bspd_queue.sv
module bspd_queue #(
  parameter int unsigned SAMPLE_BITS = bspd_pkg::SAMPLE_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  bspd_pkg::item_ctrl_t        push_ctrl_i,
  input  logic [3*SAMPLE_BITS-1:0]    push_data_i,
  input  logic                        pop_i,
  output bspd_pkg::item_ctrl_t        pop_ctrl_o,
  output logic [3*SAMPLE_BITS-1:0]    pop_data_o,
  output logic [bspd_pkg::QCNT_W-1:0] count_o
);

  localparam int unsigned QPTR_W = bspd_pkg::QPTR_W;
  localparam int unsigned QCNT_W = bspd_pkg::QCNT_W;

  bspd_pkg::item_ctrl_t     ctrl_mem [bspd_pkg::QUEUE_DEPTH];
  logic [3*SAMPLE_BITS-1:0] data_mem [bspd_pkg::QUEUE_DEPTH];

  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ctrl_mem[wr_ptr_q] <= push_ctrl_i;
      data_mem[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_ctrl_o = ctrl_mem[rd_ptr_q];
  assign pop_data_o = data_mem[rd_ptr_q];
  assign count_o    = count_q;

endmodule

// File: hw/rtl/bspd_back.sv
module bspd_back #(
  parameter int unsigned SAMPLE_BITS = bspd_pkg::SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bspd_pkg::QCNT_W-1:0]   q_count_i,
  input  bspd_pkg::item_ctrl_t          q_ctrl_i,
  input  logic [3*SAMPLE_BITS-1:0]      q_data_i,
  output logic                          pop_o,
  output logic                          demod_valid_o,
  input  logic                          demod_stall_i,
  output logic signed [SAMPLE_BITS:0]   demod_value_o,
  output logic                          out_valid_o,
  output logic                          out_last_o
);

  localparam int unsigned LOG2W = bspd_pkg::LOG2_WINDOW;
  localparam int unsigned SUM_W = SAMPLE_BITS + LOG2W + 1;
  localparam int unsigned VAL_W = SAMPLE_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] q_x, q_old, q_ctr;
  logic signed [SUM_W-1:0]       sum_base, sum_drop, sum_d;

  logic c_ready, d_ready, o_ready;

  logic                          c_v_q;
  logic signed [SUM_W-1:0]       c_sum_q;
  bspd_pkg::item_ctrl_t          c_ctrl_q;
  logic signed [SAMPLE_BITS-1:0] c_ctr_q;

  logic                          d_v_q;
  logic [VAL_W-1:0]              mean_d, d_mean_q;
  logic                          mean_corr;
  bspd_pkg::item_ctrl_t          d_ctrl_q;
  logic signed [SAMPLE_BITS-1:0] d_ctr_q;

  logic                          o_v_q;
  logic [VAL_W-1:0]              ctr_ext, value_d;
  logic signed [VAL_W-1:0]       o_value_q;
  logic                          o_valid_q, o_last_q;

  assign q_x   = q_data_i[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
  assign q_old = q_data_i[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign q_ctr = q_data_i[SAMPLE_BITS-1:0];

  assign o_ready = !o_v_q || !demod_stall_i;
  assign d_ready = !d_v_q || o_ready;
  assign c_ready = !c_v_q || d_ready;
  assign pop_o   = (q_count_i != '0) && c_ready;

  // Running sum: restart on a new record, drop the leaving sample once full.
  always_comb begin
    sum_base = q_ctrl_i.first ? '0 : c_sum_q;
    sum_drop = q_ctrl_i.drop_old ? SUM_W'(q_old) : '0;
    sum_d    = sum_base - sum_drop + SUM_W'(q_x);
  end

  // Shift floors; step up by one for a negative sum with a remainder.
  always_comb begin
    mean_corr = c_sum_q[SUM_W-1] && (|c_sum_q[LOG2W-1:0]);
    mean_d    = c_sum_q[SUM_W-1:LOG2W] + VAL_W'(mean_corr);
  end

  always_comb begin
    ctr_ext = VAL_W'(d_ctr_q);
    value_d = '0;
    if (d_ctrl_q.valid) begin
      value_d = d_ctrl_q.negate ? (d_mean_q - ctr_ext) : (ctr_ext - d_mean_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q   <= 1'b0;
      c_sum_q <= '0;
      d_v_q   <= 1'b0;
      o_v_q   <= 1'b0;
    end else begin
      if (c_ready) begin
        c_v_q <= pop_o;
      end
      if (pop_o) begin
        c_sum_q <= sum_d;
      end
      if (d_ready) begin
        d_v_q <= c_v_q;
      end
      if (o_ready) begin
        o_v_q <= d_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      c_ctrl_q <= q_ctrl_i;
      c_ctr_q  <= q_ctr;
    end
    if (d_ready && c_v_q) begin
      d_mean_q <= mean_d;
      d_ctrl_q <= c_ctrl_q;
      d_ctr_q  <= c_ctr_q;
    end
    if (o_ready && d_v_q) begin
      o_value_q <= $signed(value_d);
      o_valid_q <= d_ctrl_q.valid;
      o_last_q  <= d_ctrl_q.last;
    end
  end

  assign demod_valid_o = o_v_q;
  assign demod_value_o = o_value_q;
  assign out_valid_o   = o_valid_q;
  assign out_last_o    = o_last_q;

endmodule

// File: hw/rtl/baseline_subtract_parity_demod.sv
// Centered moving-average baseline removal with square-wave demodulation.
// Each accepted sample yields one result: the centre sample of a 1024-sample
// window minus the window mean (truncated toward zero), negated when the
// centre's absolute sample number is odd; until the window of the current
// record is full the result is zero with out_valid_o low. The block takes
// one item per cycle sustained while the output is not stalled; each result
// passes stage B, the queue and stages C, D and O. Throughput is set by the
// window memory (one write and two reads per item, at accept) and by the
// running-sum register in the back end, which updates once per item. A
// four-entry queue separates the two, so input stalls follow output stalls
// only once the queue fills. The window memory needs no clearing after
// reset: only entries written in the current record are ever used.
// start_parity is loaded on each first_of_record item.
`include "baseline_subtract_parity_demod_assert.svh"

module baseline_subtract_parity_demod #(
  parameter int unsigned SAMPLE_BITS = bspd_pkg::SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          first_of_record_i,
  input  logic                          last_of_record_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  output logic                          demod_valid_o,
  input  logic                          demod_stall_i,
  output logic signed [SAMPLE_BITS:0]   demod_value_o,
  output logic                          out_valid_o,
  output logic                          out_last_o
);

  logic                          q_push, q_pop;
  bspd_pkg::item_ctrl_t          push_ctrl, pop_ctrl;
  logic [3*SAMPLE_BITS-1:0]      push_data, pop_data;
  logic [bspd_pkg::QCNT_W-1:0]   q_count;

  bspd_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_i          (sample_i),
    .first_of_record_i (first_of_record_i),
    .last_of_record_i  (last_of_record_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .q_count_i         (q_count),
    .push_o            (q_push),
    .push_ctrl_o       (push_ctrl),
    .push_data_o       (push_data)
  );

  bspd_queue #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_ctrl_i (push_ctrl),
    .push_data_i (push_data),
    .pop_i       (q_pop),
    .pop_ctrl_o  (pop_ctrl),
    .pop_data_o  (pop_data),
    .count_o     (q_count)
  );

  bspd_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_count_i     (q_count),
    .q_ctrl_i      (pop_ctrl),
    .q_data_i      (pop_data),
    .pop_o         (q_pop),
    .demod_valid_o (demod_valid_o),
    .demod_stall_i (demod_stall_i),
    .demod_value_o (demod_value_o),
    .out_valid_o   (out_valid_o),
    .out_last_o    (out_last_o)
  );

  `BSPD_ASSERT_IMPLIES(a_no_overflow, q_push && !q_pop, q_count < bspd_pkg::QCNT_W'(bspd_pkg::QUEUE_DEPTH))
  `BSPD_ASSERT_IMPLIES(a_no_underflow, q_pop, q_count != '0)
  `BSPD_ASSERT_IMPLIES(a_zero_when_partial, demod_valid_o && !out_valid_o, demod_value_o == '0)
  `BSPD_ASSERT_NEXT(a_push_follows_accept, in_valid_i && !in_stall_o, q_push)

endmodule

// File: tb/sv/tb_top.sv
module tb_top;

  localparam int PHASE_ITEMS    = 300;
  localparam int MAX_GAP        = 40;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef logic signed [bspd_pkg::SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SMP_MAX = {1'b0, {(bspd_pkg::SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SMP_MIN = {1'b1, {(bspd_pkg::SAMPLE_BITS-1){1'b0}}};

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  class demod_scoreboard;
    typedef struct {
      logic signed [bspd_pkg::SAMPLE_BITS:0] value;
      logic                                  full;
      logic                                  last;
    } demod_exp_t;

    sample_t                        win [bspd_pkg::WINDOW_LEN];
    longint                         run_sum;
    int unsigned                    fill;
    logic [bspd_pkg::PTR_W-1:0]     wptr;
    logic                           par;
    logic                           start_par;
    int                             errors;
    demod_exp_t                     pending_demod[$];

    function new();
      run_sum   = 0;
      fill      = 0;
      wptr      = '0;
      par       = 1'b0;
      start_par = 1'b0;
      errors    = 0;
    endfunction

    // Advance the window by one accepted sample and queue its expected result.
    function void note_sample(sample_t smp, logic first, logic last);
      demod_exp_t                 e;
      logic                       p;
      logic [bspd_pkg::PTR_W-1:0] slot;
      longint                     mean;
      longint                     diff;
      if (first) begin
        fill    = 0;
        run_sum = 0;
        wptr    = '0;
        par     = start_par;
      end
      p = par;
      if (fill >= bspd_pkg::WINDOW_LEN) run_sum -= win[wptr];
      win[wptr] = smp;
      run_sum  += smp;
      if (fill < bspd_pkg::WINDOW_LEN) fill++;
      e.value = '0;
      e.full  = 1'b0;
      e.last  = last;
      if (fill >= bspd_pkg::WINDOW_LEN) begin
        slot = wptr - bspd_pkg::PTR_W'(bspd_pkg::CENTRE_LAG);
        // signed division truncates toward zero
        mean = run_sum / longint'(bspd_pkg::WINDOW_LEN);
        diff = longint'(win[slot]) - mean;
        if (p ^ bspd_pkg::CENTRE_LAG_ODD) diff = -diff;
        e.value = diff[bspd_pkg::SAMPLE_BITS:0];
        e.full  = 1'b1;
      end
      wptr++;
      par = ~p;
      pending_demod.push_back(e);
    endfunction

    function void check_result(logic signed [bspd_pkg::SAMPLE_BITS:0] value, logic full,
                               logic last);
      demod_exp_t e;
      if (pending_demod.size() == 0) begin
        errors++;
        $display("%0t: result with no item pending: value %0d valid %0b last %0b",
                 $time, value, full, last);
        return;
      end
      e = pending_demod.pop_front();
      if (value !== e.value) begin
        errors++;
        $display("%0t: demod_value expected %0d actual %0d", $time, e.value, value);
      end
      if (full !== e.full) begin
        errors++;
        $display("%0t: out_valid expected %0b actual %0b", $time, e.full, full);
      end
      if (last !== e.last) begin
        errors++;
        $display("%0t: out_last expected %0b actual %0b", $time, e.last, last);
      end
    endfunction
  endclass

  logic                                  clk_i             = 1'b0;
  logic                                  rst_ni            = 1'b0;
  logic                                  in_valid_i        = 1'b0;
  logic                                  in_stall_o;
  sample_t                               sample_i          = '0;
  logic                                  first_of_record_i = 1'b0;
  logic                                  last_of_record_i  = 1'b0;
  logic                                  cfg_we_i          = 1'b0;
  logic                                  cfg_wdata_i       = 1'b0;
  logic                                  demod_valid_o;
  logic                                  demod_stall_i     = 1'b0;
  logic signed [bspd_pkg::SAMPLE_BITS:0] demod_value_o;
  logic                                  out_valid_o;
  logic                                  out_last_o;

  demod_scoreboard sb = new();
  int              sent_items    = 0;
  int              send_idle_pct = 0;
  int              stall_pct     = 0;

  baseline_subtract_parity_demod u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_i          (sample_i),
    .first_of_record_i (first_of_record_i),
    .last_of_record_i  (last_of_record_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .demod_valid_o     (demod_valid_o),
    .demod_stall_i     (demod_stall_i),
    .demod_value_o     (demod_value_o),
    .out_valid_o       (out_valid_o),
    .out_last_o        (out_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && demod_valid_o && !demod_stall_i) begin
      sb.check_result(demod_value_o, out_valid_o, out_last_o);
    end
    demod_stall_i <= ($urandom_range(99) < stall_pct);
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (demod_valid_o && !demod_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  function automatic sample_t pick_sample(bit extreme);
    logic [31:0] r;
    r = $urandom();
    // mostly minimum with a few maximum pushes the output toward its range ends
    if (extreme) return ($urandom_range(7) == 0) ? SMP_MAX : SMP_MIN;
    case ($urandom_range(15))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return {{(bspd_pkg::SAMPLE_BITS-8){r[7]}}, r[7:0]};
      default: return r[bspd_pkg::SAMPLE_BITS-1:0];
    endcase
  endfunction

  task automatic send_sample(input sample_t smp, input logic first, input logic last);
    int gap;
    gap = 0;
    case (idle_mode_e'((sent_items / PHASE_ITEMS) % 4))
      IDLE_NONE: begin send_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 68; stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 68; end
      default:   begin send_idle_pct = 24; stall_pct = 24; end
    endcase
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    sample_i          <= smp;
    first_of_record_i <= first;
    last_of_record_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(smp, first, last);
    sent_items++;
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    while (sb.pending_demod.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_start_parity(input logic v);
    hold_until_drained();
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    sb.start_par = v;
    cfg_we_i    <= 1'b0;
  endtask

  // cont: keep the running record; broken: sprinkle restarts mid record
  task automatic run_record(input int len, input bit cont, input bit extreme, input bit broken);
    logic first;
    logic last;
    for (int i = 0; i < len; i++) begin
      first = ((i == 0) && !cont) || (broken && $urandom_range(15) == 0);
      last  = (i == len - 1) || ($urandom_range(63) == 0);
      send_sample(pick_sample(extreme), first, last);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no restart after reset: parity starts even, record runs on past last
    send_sample('0, 1'b0, 1'b0);
    send_sample(SMP_MAX, 1'b0, 1'b0);
    send_sample(SMP_MIN, 1'b0, 1'b0);
    send_sample(sample_t'(-1), 1'b0, 1'b1);
    send_sample(sample_t'(1), 1'b0, 1'b0);
    send_sample(SMP_MAX, 1'b0, 1'b1);
    write_start_parity(1'b1);
    send_sample(SMP_MIN, 1'b1, 1'b0);
    send_sample(SMP_MAX, 1'b0, 1'b0);
    send_sample(24'sh555555, 1'b0, 1'b0);
    send_sample(24'shaaaaaa, 1'b0, 1'b1);
    send_sample(sample_t'(123), 1'b0, 1'b0);
    send_sample(SMP_MIN, 1'b1, 1'b1);
    send_sample(SMP_MAX, 1'b1, 1'b0);
    write_start_parity(1'b0);
    send_sample(sample_t'(-5), 1'b1, 1'b0);
    send_sample(sample_t'(7), 1'b0, 1'b1);

    // full record with odd start, extremes first, sender held mid record until drained
    write_start_parity(1'b1);
    run_record(620, 1'b0, 1'b1, 1'b0);
    hold_until_drained();
    run_record(460, 1'b1, 1'b0, 1'b0);

    repeat (3) begin
      write_start_parity(1'($urandom_range(1)));
      run_record($urandom_range(3, 60), 1'b0, 1'b0, 1'b1);
    end

    // short record with even start
    write_start_parity(1'b0);
    run_record(150, 1'b0, 1'b0, 1'b0);

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_demod.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: baseline_subtract_parity_demod.f
+incdir+hw/rtl
hw/rtl/bspd_pkg.sv
hw/rtl/bspd_front.sv
hw/rtl/bspd_queue.sv
hw/rtl/bspd_back.sv
hw/rtl/baseline_subtract_parity_demod.sv
tb/sv/tb_top.sv
